### sv/sts_pkg.sv
package sts_pkg;

  // Byte codes the parser reacts to
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_P_LO   = 8'h70;
  localparam logic [7:0] CH_N_LO   = 8'h6E;
  localparam logic [7:0] CH_N_UP   = 8'h4E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Parser modes
  typedef enum logic [7:0] {
    M_PLAIN    = 8'b0000_0001,
    M_PLAIN_BS = 8'b0000_0010,
    M_TAG      = 8'b0000_0100,
    M_TAG_BS   = 8'b0000_1000,
    M_TAG_BSP  = 8'b0001_0000,
    M_INT      = 8'b0010_0000,
    M_FRAC1    = 8'b0100_0000,
    M_FRACN    = 8'b1000_0000
  } sts_mode_t;

  // Results caused by one item: one, or two when two is set
  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic       e0;
    logic [7:0] c1;
    logic       e1;
  } sts_job_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } sts_qstat_t;

endpackage

### sv/sts_front.sv
module sts_front
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_in,
  input  sts_qstat_t qstat,
  output logic       push,
  output sts_job_t   push_job
);

  sts_mode_t mode_r, mode_nxt;
  logic      draw_r, draw_nxt;
  logic      inz_r, inz_nxt;
  logic      fhu_r, fhu_nxt;

  logic      acc;
  logic      is_dig;
  logic      pl_emit;
  sts_mode_t pl_mode;
  sts_mode_t tg_mode;
  logic [1:0] cnt;
  sts_job_t  job;

  assign in_stall = qstat.full;
  assign acc      = in_valid && !qstat.full;
  assign is_dig   = (in_char_in >= CH_ZERO) && (in_char_in <= CH_NINE);

  // Classify the byte as plain text and as tag content
  always_comb begin
    if (in_char_in == CH_LBRACE) begin
      pl_mode = M_TAG;
    end else if (in_char_in == CH_BSLASH) begin
      pl_mode = M_PLAIN_BS;
    end else begin
      pl_mode = M_PLAIN;
    end
    if (in_char_in == CH_RBRACE) begin
      tg_mode = M_PLAIN;
    end else if (in_char_in == CH_BSLASH) begin
      tg_mode = M_TAG_BS;
    end else begin
      tg_mode = M_TAG;
    end
  end

  assign pl_emit = (pl_mode == M_PLAIN) && !draw_r;

  // Next state and results of this item
  always_comb begin
    mode_nxt = mode_r;
    draw_nxt = draw_r;
    inz_nxt  = inz_r;
    fhu_nxt  = fhu_r;
    cnt      = 2'd0;
    job      = '0;
    if (in_end_in) begin
      if ((mode_r == M_PLAIN_BS) && !draw_r) begin
        job.c0 = CH_BSLASH;
        job.two = 1'b1;
        job.c1 = CH_NUL;
        job.e1 = 1'b1;
        cnt = 2'd2;
      end else begin
        job.c0 = CH_NUL;
        job.e0 = 1'b1;
        cnt = 2'd1;
      end
      mode_nxt = M_PLAIN;
      draw_nxt = 1'b0;
      inz_nxt  = 1'b0;
      fhu_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        M_PLAIN: begin
          mode_nxt = pl_mode;
          if (pl_emit) begin
            job.c0 = in_char_in;
            cnt = 2'd1;
          end
        end
        M_PLAIN_BS: begin
          if ((in_char_in == CH_N_LO) || (in_char_in == CH_N_UP)) begin
            job.c0 = CH_NL;
            cnt = 2'd1;
            mode_nxt = M_PLAIN;
          end else begin
            mode_nxt = pl_mode;
            if (!draw_r) begin
              job.c0 = CH_BSLASH;
              cnt = 2'd1;
              if (pl_emit) begin
                job.two = 1'b1;
                job.c1 = in_char_in;
                cnt = 2'd2;
              end
            end
          end
        end
        M_TAG: begin
          mode_nxt = tg_mode;
        end
        M_TAG_BS: begin
          if (in_char_in == CH_P_LO) begin
            mode_nxt = M_TAG_BSP;
          end else begin
            mode_nxt = tg_mode;
          end
        end
        M_TAG_BSP: begin
          if (is_dig) begin
            inz_nxt  = (in_char_in != CH_ZERO);
            fhu_nxt  = 1'b0;
            mode_nxt = M_INT;
          end else begin
            mode_nxt = tg_mode;
          end
        end
        M_INT: begin
          if (is_dig) begin
            if (in_char_in != CH_ZERO) begin
              inz_nxt = 1'b1;
            end
          end else if (in_char_in == CH_DOT) begin
            mode_nxt = M_FRAC1;
          end else begin
            draw_nxt = inz_r || fhu_r;
            inz_nxt  = 1'b0;
            fhu_nxt  = 1'b0;
            mode_nxt = tg_mode;
          end
        end
        M_FRAC1: begin
          if (is_dig) begin
            fhu_nxt  = (in_char_in >= CH_FIVE);
            mode_nxt = M_FRACN;
          end else begin
            draw_nxt = inz_r || fhu_r;
            inz_nxt  = 1'b0;
            fhu_nxt  = 1'b0;
            mode_nxt = tg_mode;
          end
        end
        M_FRACN: begin
          if (!is_dig) begin
            draw_nxt = inz_r || fhu_r;
            inz_nxt  = 1'b0;
            fhu_nxt  = 1'b0;
            mode_nxt = tg_mode;
          end
        end
        default: begin
          mode_nxt = M_PLAIN;
        end
      endcase
    end
  end

  assign push     = acc && (cnt != 2'd0);
  assign push_job = job;

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      draw_r <= 1'b0;
      inz_r  <= 1'b0;
      fhu_r  <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      draw_r <= draw_nxt;
      inz_r  <= inz_nxt;
      fhu_r  <= fhu_nxt;
    end
  end

endmodule

### sv/sts_queue.sv
module sts_queue
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sts_job_t   push_job,
  input  logic       pop,
  output sts_job_t   head,
  output sts_qstat_t qstat
);

  sts_job_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign qstat.full  = (cnt_r == QCW'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue fill count above depth");

endmodule

### sv/sts_back.sv
module sts_back
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sts_qstat_t qstat,
  input  sts_job_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_end_out,
  output logic       out_last
);

  sts_job_t cur_r;
  logic     vld_r, vld_nxt;
  logic     sel_r, sel_nxt;
  logic     fin;
  logic     done;
  logic     load;

  assign fin  = !cur_r.two || sel_r;
  assign done = vld_r && !out_stall && fin;
  assign load = !vld_r || done;
  assign pop  = load && !qstat.empty;

  assign out_valid    = vld_r;
  assign out_char_out = sel_r ? cur_r.c1 : cur_r.c0;
  assign out_end_out  = sel_r ? cur_r.e1 : cur_r.e0;
  assign out_last     = fin;

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (load) begin
      vld_nxt = !qstat.empty;
      sel_nxt = 1'b0;
    end else if (vld_r && !out_stall) begin
      sel_nxt = 1'b1;
    end
  end

  // Load next entry or step to its second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_out) |-> out_last)
    else $error("terminator result not marked last");

  a_sel_only_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (vld_r && cur_r.two))
    else $error("second result selected on single-result entry");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_stall && !fin) |=> (vld_r && sel_r))
    else $error("second result lost after first was taken");

endmodule

### sv/subtitle_tag_stripper_unit.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_char_in[7:0], in_end_in
// out_     output     out_valid/out_stall out_char_out[7:0], out_end_out, out_last
//
// Takes one byte item per cycle while not stalled; the parser state updates in
// the accepting cycle. Results pass through the queue, then the output register;
// an item with two results holds it until both are taken, and a four-entry queue
// absorbs the difference. in_stall rises only when that queue is full; out_stall
// never blocks the parser until then. Synchronous active-low reset returns parser
// to plain text, empties the queue and drops the output register.
module subtitle_tag_stripper_unit
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_end_out,
  output logic       out_last
);

  sts_qstat_t qstat;
  sts_job_t   push_job;
  sts_job_t   head;
  logic       push;
  logic       pop;

  sts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .in_end_in  (in_end_in),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  sts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  sts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_end_out  (out_end_out),
    .out_last     (out_last)
  );

endmodule
